// ===== sv/tbwp_pkg.sv =====
// ----------------------------------------------------------------------------
// tbwp_pkg: shared types and constants of the background and window pixel fetch
// payload structs, register indexes, memory layout and shade lookup
// ----------------------------------------------------------------------------
package tbwp_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    // request codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_LCD_CONTROL = 3'd0;
    localparam logic [2:0] CFG_SCROLL_X    = 3'd1;
    localparam logic [2:0] CFG_SCROLL_Y    = 3'd2;
    localparam logic [2:0] CFG_WINDOW_X    = 3'd3;
    localparam logic [2:0] CFG_WINDOW_Y    = 3'd4;

    localparam logic [7:0] LCD_CONTROL_RESET = 8'h91;

    // lcd_control bit positions
    localparam int LCDC_BG_MAP    = 3;
    localparam int LCDC_TILE_MODE = 4;
    localparam int LCDC_WIN_EN    = 5;
    localparam int LCDC_WIN_MAP   = 6;

    // offsets from the start of video memory (0x8000)
    localparam logic [12:0] MAP_LOW_OFS   = 13'h1800;   // 0x9800
    localparam logic [12:0] MAP_HIGH_OFS  = 13'h1C00;   // 0x9c00
    localparam logic [12:0] DATA_UNS_OFS  = 13'h0000;   // 0x8000
    localparam logic [12:0] DATA_LOW_OFS  = 13'h1000;   // 0x9000
    localparam logic [12:0] DATA_HIGH_OFS = 13'h0800;   // 0x8800

    localparam logic [10:0] WIN_X_BIAS = 11'd7;

    typedef struct packed {
        logic        func;
        logic [12:0] mem_offset;
        logic [7:0]  mem_data;
        logic [7:0]  column;
        logic [7:0]  line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] shade;
        logic [1:0] color_index;
        logic       from_window;
    } out_item_t;

    // start of a tile's sixteen bytes
    function automatic logic [12:0] tile_base(input logic [7:0] id, input logic uns_mode);
        logic [12:0] base;
        begin
            if (uns_mode) begin
                base = DATA_UNS_OFS + {1'b0, id, 4'b0};
            end else if (!id[7]) begin
                base = DATA_LOW_OFS + {2'b0, id[6:0], 4'b0};
            end else begin
                base = DATA_HIGH_OFS + {2'b0, id[6:0], 4'b0};
            end
            return base;
        end
    endfunction

    function automatic logic [7:0] shade_of(input logic [1:0] color);
        logic [7:0] s;
        begin
            case (color)
                2'd0:    s = 8'd255;
                2'd1:    s = 8'd200;
                2'd2:    s = 8'd125;
                default: s = 8'd75;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== sv/tbwp_ram.sv =====
// ----------------------------------------------------------------------------
// tbwp_ram: generic single clock ram
// one write port, one read port with enable and registered read data
// ----------------------------------------------------------------------------
module tbwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/tile_background_window_pixel.sv =====
// ----------------------------------------------------------------------------
// tile_background_window_pixel: background and window pixel fetch
// video memory of 8 KiB and a three read sequencer that turns a screen
// position into a tile colour and grey shade
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    in_item_t  (write byte or render)
//  m_        out        m_valid / m_ready    out_item_t (one per render)
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  a write request is written at acceptance; a render request runs from
//  acceptance to the result register through the three dependent reads of the
//  single video memory read port (map entry, low plane, high plane)
//  s_ready is low while a render is in flight, so the next request is taken
//  only after the result loads: renders never overlap
//  a result held by m_ready low stalls the sequencer in its last step, and
//  s_ready stays low until it can load, writes included
//  reset clears the sequencer, the output valid and the config registers; the video
//  memory has no reset and needs no clearing pass
//  cfg_ready is always high, config writes to unknown indexes are dropped
//
module tile_background_window_pixel
    import tbwp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,

    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // sequencer codes
    localparam logic [1:0] S_IDLE = 2'd0;  // map read issued on acceptance
    localparam logic [1:0] S_LO   = 2'd1;  // tile id back, low plane read
    localparam logic [1:0] S_HI   = 2'd2;  // low plane back, high plane read
    localparam logic [1:0] S_OUT  = 2'd3;  // high plane back, load result

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic [7:0] lcdc_reg, scx_reg, scy_reg, wx_reg, wy_reg;

    // per render working registers
    logic [2:0]  bit_sel_reg, bit_sel_next;   // pixel column within tile
    logic [2:0]  row_reg, row_next;           // pixel row within tile
    logic        win_reg, win_next;
    logic [12:0] row_addr_reg, row_addr_next; // even byte of the tile row
    logic [7:0]  lo_reg, lo_next;

    // output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // ram port signals
    logic               ram_we, ram_re;
    logic [VRAM_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;

    // map point and window test, straight from the request
    logic [7:0]  map_x, map_y;
    logic [10:0] dx, dy;
    logic        win_hit;
    logic [7:0]  pix_x, pix_y;
    logic        map_sel;
    logic [12:0] map_addr;
    logic [12:0] tile_addr;
    logic [1:0]  color;
    logic        s_acc;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // window origin taken without wrap: 11 bits hold the full difference range,
    // so a distance of 0 to 255 is exactly the case with the top three bits clear
    always_comb begin
        map_x   = scx_reg + s_data.column;
        map_y   = scy_reg + s_data.line;
        dx      = {3'b0, map_x} + WIN_X_BIAS - {3'b0, wx_reg} - {3'b0, scx_reg};
        dy      = {3'b0, map_y} - {3'b0, wy_reg} - {3'b0, scy_reg};
        win_hit = lcdc_reg[LCDC_WIN_EN] && (dx[10:8] == 3'b0) && (dy[10:8] == 3'b0);
        pix_x   = win_hit ? dx[7:0] : map_x;
        pix_y   = win_hit ? dy[7:0] : map_y;
        map_sel = win_hit ? lcdc_reg[LCDC_WIN_MAP] : lcdc_reg[LCDC_BG_MAP];
        // 32 by 32 entries of one byte
        map_addr = (map_sel ? MAP_HIGH_OFS : MAP_LOW_OFS) + {3'b0, pix_y[7:3], pix_x[7:3]};
    end

    // tile row address from the id just read
    assign tile_addr = tile_base(ram_rdata, lcdc_reg[LCDC_TILE_MODE]);

    // pixel bit 7 is the leftmost; ~bit_sel is 7 - column in tile
    assign color = {ram_rdata[~bit_sel_reg], lo_reg[~bit_sel_reg]};

    // sequencer and ram read port
    always_comb begin
        state_next    = state_reg;
        bit_sel_next  = bit_sel_reg;
        row_next      = row_reg;
        win_next      = win_reg;
        row_addr_next = row_addr_reg;
        lo_next       = lo_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = map_addr;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_data.func == FUNC_WRITE) begin
                        ram_we = 1'b1;
                    end else begin
                        ram_re       = 1'b1;
                        bit_sel_next = pix_x[2:0];
                        row_next     = pix_y[2:0];
                        win_next     = win_hit;
                        state_next   = S_LO;
                    end
                end
            end
            S_LO: begin
                ram_re        = 1'b1;
                row_addr_next = {tile_addr[12:4], row_reg, 1'b0};
                ram_raddr     = row_addr_next;
                state_next    = S_HI;
            end
            S_HI: begin
                ram_re     = 1'b1;
                ram_raddr  = {row_addr_reg[12:1], 1'b1};
                lo_next    = ram_rdata;
                state_next = S_OUT;
            end
            S_OUT: begin
                // read data holds while the result register is still full
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.shade       = shade_of(color);
                    m_data_next.color_index = color;
                    m_data_next.from_window = win_reg;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    tbwp_ram #(
        .WIDTH (8),
        .DEPTH (VRAM_BYTES)
    ) u_vram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s_data.mem_offset[VRAM_AW-1:0]),
        .wr_data (s_data.mem_data),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            lcdc_reg    <= LCD_CONTROL_RESET;
            scx_reg     <= 8'd0;
            scy_reg     <= 8'd0;
            wx_reg      <= 8'd0;
            wy_reg      <= 8'd0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_LCD_CONTROL: lcdc_reg <= cfg_data;
                    CFG_SCROLL_X:    scx_reg  <= cfg_data;
                    CFG_SCROLL_Y:    scy_reg  <= cfg_data;
                    CFG_WINDOW_X:    wx_reg   <= cfg_data;
                    CFG_WINDOW_Y:    wy_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        bit_sel_reg  <= bit_sel_next;
        row_reg      <= row_next;
        win_reg      <= win_next;
        row_addr_reg <= row_addr_next;
        lo_reg       <= lo_next;
        m_data_reg   <= m_data_next;
    end

endmodule
